FILE: src/dmp_pkg.sv
// Shared constants, types and helpers of the defrag move planner.
package dmp_pkg;

   localparam int MAX_CLUSTERS = 32;
   localparam int IDX_W        = $clog2(MAX_CLUSTERS);
   localparam int CL_W         = 6;
   localparam int ST_W         = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CL_W-1:0] MAX_CL       = CL_W'(MAX_CLUSTERS);
   localparam logic [CL_W-1:0] NUM_CL_RESET = CL_W'(32);

   localparam logic [ST_W-1:0] ST_MOVE = 2'd0;
   localparam logic [ST_W-1:0] ST_NONE = 2'd1;
   localparam logic [ST_W-1:0] ST_ERR  = 2'd2;

   typedef struct packed {
      logic            store;
      logic            plan;
      logic            err;
      logic [CL_W-1:0] piece;
      logic [CL_W-1:0] cluster;
   } qent_type;

   typedef struct packed {
      logic            strobe;
      logic [CL_W-1:0] src;
      logic [CL_W-1:0] dst;
      logic [ST_W-1:0] status;
      logic            last;
   } rsp_type;

   // cluster or piece number (1-based) to table index
   function automatic logic [IDX_W-1:0] cl_idx(input logic [CL_W-1:0] c);
      logic [CL_W-1:0] m;
      m = c - CL_W'(1);
      return m[IDX_W-1:0];
   endfunction

endpackage

FILE: src/dmp_front.sv
// Front end: accepts pieces, checks range, duplicates and count, queues work.
module dmp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [dmp_pkg::CL_W-1:0] req_cluster,
   input  logic                   req_last_piece,
   input  logic [dmp_pkg::CL_W-1:0] disk_size,
   input  logic                   queue_full,
   output logic                   busy,
   output logic                   push,
   output dmp_pkg::qent_type      push_ent
);

   logic [dmp_pkg::MAX_CLUSTERS-1:0] occ_ff, occ_in;
   logic [dmp_pkg::CL_W-1:0]         count_ff, count_in;
   logic                             err_ff, err_in;
   logic [dmp_pkg::IDX_W-1:0]        idx;
   logic                             accept, in_range, dup, full, ok;

   assign busy     = queue_full;
   assign accept   = start && !queue_full;
   assign idx      = dmp_pkg::cl_idx(req_cluster);
   assign in_range = (req_cluster != '0) && (req_cluster <= disk_size);
   assign dup      = occ_ff[idx];
   assign full     = count_ff >= dmp_pkg::MAX_CL;
   assign ok       = in_range && !dup && !full;

   always_comb begin
      occ_in   = occ_ff;
      count_in = count_ff;
      err_in   = err_ff;
      push     = accept && (ok || req_last_piece);
      push_ent.store   = ok;
      push_ent.plan    = req_last_piece;
      push_ent.err     = err_ff || !ok;
      push_ent.piece   = ok ? count_ff + dmp_pkg::CL_W'(1) : count_ff;
      push_ent.cluster = req_cluster;
      if (accept) begin
         if (req_last_piece) begin
            occ_in   = '0;
            count_in = '0;
            err_in   = 1'b0;
         end else if (ok) begin
            occ_in[idx] = 1'b1;
            count_in    = count_ff + dmp_pkg::CL_W'(1);
         end else begin
            err_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         count_ff <= '0;
         err_ff   <= 1'b0;
      end else begin
         occ_ff   <= occ_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

endmodule

FILE: src/dmp_queue.sv
// Short FIFO between the front end and the planning sequencer.
module dmp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dmp_pkg::qent_type push_ent,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output dmp_pkg::qent_type head
);

   dmp_pkg::qent_type                q_mem [dmp_pkg::QUEUE_DEPTH];
   logic [dmp_pkg::QPTR_W-1:0]       wptr_ff, rptr_ff;
   logic [dmp_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                             do_push, do_pop;

   assign full    = cnt_ff == dmp_pkg::QCNT_W'(dmp_pkg::QUEUE_DEPTH);
   assign valid   = cnt_ff != '0;
   assign head    = q_mem[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + dmp_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - dmp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) wptr_ff <= wptr_ff + dmp_pkg::QPTR_W'(1);
         if (do_pop)  rptr_ff <= rptr_ff + dmp_pkg::QPTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_mem[wptr_ff] <= push_ent;
   end

endmodule

FILE: src/dmp_back.sv
// Back end: table writes, free-cluster scan and move walk sequencer.
module dmp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  dmp_pkg::qent_type        q_head,
   input  logic [dmp_pkg::CL_W-1:0] disk_size,
   output logic                     pop,
   output dmp_pkg::rsp_type         rsp
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SCAN = 7'b0000010,
      S_RD   = 7'b0000100,
      S_EVAL = 7'b0001000,
      S_W1   = 7'b0010000,
      S_W2   = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [dmp_pkg::CL_W-1:0] own_mem [dmp_pkg::MAX_CLUSTERS];
   logic [dmp_pkg::CL_W-1:0] loc_mem [dmp_pkg::MAX_CLUSTERS];
   logic [dmp_pkg::MAX_CLUSTERS-1:0] vld_ff, vld_in;

   logic [dmp_pkg::CL_W-1:0] own_rd_ff, loc_rd_ff;
   logic                     own_vrd_ff;

   logic [dmp_pkg::CL_W-1:0] i_ff, i_in, freec_ff, freec_in, from_ff, from_in;
   logic [dmp_pkg::CL_W-1:0] occup_ff, occup_in, cnt_ff, cnt_in, scan_ff, scan_in;
   logic                     pend_ff, pend_in;
   logic [dmp_pkg::CL_W-1:0] pend_src_ff, pend_src_in, pend_dst_ff, pend_dst_in;

   logic                      own_we, loc_we, clr_all;
   logic [dmp_pkg::IDX_W-1:0] own_waddr, loc_waddr;
   logic [dmp_pkg::CL_W-1:0]  own_wdata, loc_wdata, occupant;

   logic                     prod;
   logic [dmp_pkg::CL_W-1:0] prod_src, prod_dst;
   dmp_pkg::rsp_type         emit, rsp_ff;

   assign rsp      = rsp_ff;
   assign occupant = own_vrd_ff ? own_rd_ff : '0;

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      freec_in    = freec_ff;
      from_in     = from_ff;
      occup_in    = occup_ff;
      cnt_in      = cnt_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pend_src_in = pend_src_ff;
      pend_dst_in = pend_dst_ff;
      pop         = 1'b0;
      own_we      = 1'b0;
      own_waddr   = '0;
      own_wdata   = '0;
      loc_we      = 1'b0;
      loc_waddr   = '0;
      loc_wdata   = '0;
      clr_all     = 1'b0;
      prod        = 1'b0;
      prod_src    = '0;
      prod_dst    = '0;
      emit        = '0;

      unique case (state_ff)
         S_IDLE: begin
            pop = q_valid;
            if (q_valid) begin
               if (q_head.store) begin
                  own_we    = 1'b1;
                  own_waddr = dmp_pkg::cl_idx(q_head.cluster);
                  own_wdata = q_head.piece;
                  loc_we    = 1'b1;
                  loc_waddr = dmp_pkg::cl_idx(q_head.piece);
                  loc_wdata = q_head.cluster;
               end
               if (q_head.plan) begin
                  cnt_in = q_head.piece;
                  if (q_head.err) begin
                     emit.strobe = 1'b1;
                     emit.status = dmp_pkg::ST_ERR;
                     emit.last   = 1'b1;
                     clr_all     = 1'b1;
                  end else begin
                     scan_in  = dmp_pkg::CL_W'(1);
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (scan_ff > disk_size) begin
               emit.strobe = 1'b1;
               emit.status = dmp_pkg::ST_ERR;
               emit.last   = 1'b1;
               clr_all     = 1'b1;
               state_in    = S_IDLE;
            end else if (!vld_ff[dmp_pkg::cl_idx(scan_ff)]) begin
               freec_in = scan_ff;
               i_in     = dmp_pkg::CL_W'(1);
               state_in = S_RD;
            end else begin
               scan_in = scan_ff + dmp_pkg::CL_W'(1);
            end
         end
         S_RD: begin
            state_in = (i_ff > cnt_ff) ? S_FIN : S_EVAL;
         end
         S_EVAL: begin
            from_in  = loc_rd_ff;
            occup_in = occupant;
            if (loc_rd_ff == i_ff) begin
               i_in     = i_ff + dmp_pkg::CL_W'(1);
               state_in = S_RD;
            end else begin
               if ((i_ff != freec_ff) && (occupant != '0)) begin
                  prod     = 1'b1;
                  prod_src = i_ff;
                  prod_dst = freec_ff;
               end
               state_in = S_W1;
            end
         end
         S_W1: begin
            prod     = 1'b1;
            prod_src = from_ff;
            prod_dst = i_ff;
            if (freec_ff != i_ff) begin
               own_we    = 1'b1;
               own_waddr = dmp_pkg::cl_idx(freec_ff);
               own_wdata = occup_ff;
            end
            if (occup_ff != '0) begin
               loc_we    = 1'b1;
               loc_waddr = dmp_pkg::cl_idx(occup_ff);
               loc_wdata = freec_ff;
            end
            state_in = S_W2;
         end
         S_W2: begin
            own_we    = 1'b1;
            own_waddr = dmp_pkg::cl_idx(from_ff);
            own_wdata = '0;
            freec_in  = from_ff;
            i_in      = i_ff + dmp_pkg::CL_W'(1);
            state_in  = S_RD;
         end
         S_FIN: begin
            emit.strobe = 1'b1;
            emit.last   = 1'b1;
            if (pend_ff) begin
               emit.src    = pend_src_ff;
               emit.dst    = pend_dst_ff;
               emit.status = dmp_pkg::ST_MOVE;
            end else begin
               emit.status = dmp_pkg::ST_NONE;
            end
            pend_in  = 1'b0;
            clr_all  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hold each move back one step so the final one can carry last
      if (prod) begin
         if (pend_ff) begin
            emit.strobe = 1'b1;
            emit.src    = pend_src_ff;
            emit.dst    = pend_dst_ff;
            emit.status = dmp_pkg::ST_MOVE;
            emit.last   = 1'b0;
         end
         pend_in     = 1'b1;
         pend_src_in = prod_src;
         pend_dst_in = prod_dst;
      end

      vld_in = vld_ff;
      if (own_we) vld_in[own_waddr] = 1'b1;
      if (clr_all) vld_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= '0;
         pend_ff  <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         pend_ff  <= pend_in;
         rsp_ff   <= emit;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      freec_ff      <= freec_in;
      from_ff       <= from_in;
      occup_ff      <= occup_in;
      cnt_ff        <= cnt_in;
      scan_ff       <= scan_in;
      pend_src_ff   <= pend_src_in;
      pend_dst_ff   <= pend_dst_in;
   end

   always_ff @(posedge clock) begin
      if (own_we) own_mem[own_waddr] <= own_wdata;
      if (loc_we) loc_mem[loc_waddr] <= loc_wdata;
      own_rd_ff  <= own_mem[dmp_pkg::cl_idx(i_ff)];
      loc_rd_ff  <= loc_mem[dmp_pkg::cl_idx(i_ff)];
      own_vrd_ff <= vld_ff[dmp_pkg::cl_idx(i_ff)];
   end

endmodule

FILE: src/defrag_move_planner.sv
// Defrag move planner top: disk size register, front end, queue, back end.
// Load: one piece per cycle while the 4-beat queue has room; busy = queue full.
// Planning after the last piece: free-cluster scan, then read and evaluate steps per piece,
// W1 and W2 write steps per moved piece and a finish step; results leave from a register.
// Results leave as strobed one-cycle beats; the receiver cannot stall.
// Synchronous reset: disk size 32, tables and queue empty, no pending result.
module defrag_move_planner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [dmp_pkg::CL_W-1:0] req_cluster,
   input  logic                     req_last_piece,
   output logic                     rsp_strobe,
   output logic [dmp_pkg::CL_W-1:0] rsp_src_cluster,
   output logic [dmp_pkg::CL_W-1:0] rsp_dst_cluster,
   output logic [dmp_pkg::ST_W-1:0] rsp_status,
   output logic                     rsp_last_result,
   input  logic                     csr_we,
   input  logic [dmp_pkg::CL_W-1:0] csr_wdata
);

   logic [dmp_pkg::CL_W-1:0] num_clusters_ff, disk_size;
   logic                     queue_full, push, q_valid, pop;
   dmp_pkg::qent_type        push_ent, q_head;
   dmp_pkg::rsp_type         rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_clusters_ff <= dmp_pkg::NUM_CL_RESET;
      end else if (csr_we) begin
         num_clusters_ff <= csr_wdata;
      end
   end

   assign disk_size = (num_clusters_ff > dmp_pkg::MAX_CL) ? dmp_pkg::MAX_CL : num_clusters_ff;

   dmp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_cluster    (req_cluster),
      .req_last_piece (req_last_piece),
      .disk_size      (disk_size),
      .queue_full     (queue_full),
      .busy           (busy),
      .push           (push),
      .push_ent       (push_ent)
   );

   dmp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .pop      (pop),
      .full     (queue_full),
      .valid    (q_valid),
      .head     (q_head)
   );

   dmp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .disk_size (disk_size),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_strobe      = rsp.strobe;
   assign rsp_src_cluster = rsp.src;
   assign rsp_dst_cluster = rsp.dst;
   assign rsp_status      = rsp.status;
   assign rsp_last_result = rsp.last;

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the defrag move planner: directed and random disk runs against a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE = 300;
   localparam int LIMIT  = 500000;

   typedef struct packed {
      logic [dmp_pkg::CL_W-1:0] src;
      logic [dmp_pkg::CL_W-1:0] dst;
      logic [dmp_pkg::ST_W-1:0] status;
      logic                     fin;
   } move_type;

   typedef struct {
      logic [dmp_pkg::CL_W-1:0] cl;
      logic                     lastp;
   } piece_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [dmp_pkg::CL_W-1:0] req_cluster = '0;
   logic                     req_last_piece = 1'b0;
   logic                     rsp_strobe;
   logic [dmp_pkg::CL_W-1:0] rsp_src_cluster;
   logic [dmp_pkg::CL_W-1:0] rsp_dst_cluster;
   logic [dmp_pkg::ST_W-1:0] rsp_status;
   logic                     rsp_last_result;
   logic                     csr_we = 1'b0;
   logic [dmp_pkg::CL_W-1:0] csr_wdata = '0;

   piece_beat_type  piece_q[$];
   piece_beat_type  drv_beat;
   move_type        move_q[$];
   int              idle_pct = 10;
   int              fails = 0;
   int              cycles = 0;

   // expected planner state
   logic [dmp_pkg::CL_W-1:0] disk_cfg = dmp_pkg::NUM_CL_RESET;
   int              loc [1:dmp_pkg::MAX_CLUSTERS];
   int              owner [0:dmp_pkg::MAX_CLUSTERS];
   int              loaded = 0;
   logic            load_bad = 1'b0;

   defrag_move_planner i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cluster     (req_cluster),
      .req_last_piece  (req_last_piece),
      .rsp_strobe      (rsp_strobe),
      .rsp_src_cluster (rsp_src_cluster),
      .rsp_dst_cluster (rsp_dst_cluster),
      .rsp_status      (rsp_status),
      .rsp_last_result (rsp_last_result),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int eff_size(input logic [dmp_pkg::CL_W-1:0] v);
      return (int'(v) > dmp_pkg::MAX_CLUSTERS) ? dmp_pkg::MAX_CLUSTERS : int'(v);
   endfunction

   function automatic void emit_move(input int s, input int d,
                                     input logic [dmp_pkg::ST_W-1:0] st);
      move_q.insert(move_q.size(),
                    '{dmp_pkg::CL_W'(s), dmp_pkg::CL_W'(d), st, 1'b0});
   endfunction

   // loads one piece; on the last piece plans the moves and clears the tables
   function automatic void load_piece(input logic [dmp_pkg::CL_W-1:0] cl,
                                      input logic lastp);
      int     n;
      int     c;
      int     freec;
      int     from;
      int     occ;
      int     made;
      n = eff_size(disk_cfg);
      c = int'(cl);
      if (c < 1 || c > n) begin
         load_bad = 1'b1;
      end else if (owner[c] != 0) begin
         load_bad = 1'b1;
      end else if (loaded >= dmp_pkg::MAX_CLUSTERS) begin
         load_bad = 1'b1;
      end else begin
         loaded++;
         loc[loaded] = c;
         owner[c] = loaded;
      end
      if (!lastp) return;
      freec = 0;
      made = 0;
      if (!load_bad) begin
         for (int k = n; k >= 1; k--) begin
            if (owner[k] == 0) freec = k;
         end
      end
      if (load_bad || freec == 0) begin
         move_q.insert(move_q.size(), '{'0, '0, dmp_pkg::ST_ERR, 1'b1});
      end else begin
         for (int i = 1; i <= loaded; i++) begin
            from = loc[i];
            if (from != i) begin
               occ = owner[i];
               if (i != freec && occ != 0) begin
                  emit_move(i, freec, dmp_pkg::ST_MOVE);
                  made++;
               end
               emit_move(from, i, dmp_pkg::ST_MOVE);
               made++;
               owner[freec] = occ;
               if (occ != 0) loc[occ] = freec;
               freec = from;
               owner[freec] = 0;
               loc[i] = i;
               owner[i] = i;
            end
         end
         if (made == 0) begin
            move_q.insert(move_q.size(), '{'0, '0, dmp_pkg::ST_NONE, 1'b1});
         end else begin
            move_q[move_q.size() - 1].fin = 1'b1;
         end
      end
      for (int k = 0; k <= dmp_pkg::MAX_CLUSTERS; k++) owner[k] = 0;
      loaded = 0;
      load_bad = 1'b0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) load_piece(req_cluster, req_last_piece);
         if (!start || !busy) begin
            if (piece_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               drv_beat = piece_q.pop_front();
               start <= 1'b1;
               req_cluster <= drv_beat.cl;
               req_last_piece <= drv_beat.lastp;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      move_type got;
      move_type want;
      got = '{rsp_src_cluster, rsp_dst_cluster, rsp_status, rsp_last_result};
      if (!reset && rsp_strobe) begin
         if (move_q.size() == 0) begin
            fails++;
            if (fails <= 10)
               $display("unexpected result beat: src=%0d dst=%0d status=%0d last=%0b",
                        got.src, got.dst, got.status, got.fin);
         end else begin
            want = move_q.pop_front();
            if (got.src !== want.src || got.dst !== want.dst ||
                got.status !== want.status || got.fin !== want.fin) begin
               fails++;
               if (fails <= 10)
                  $display("mismatch: expected src=%0d dst=%0d status=%0d last=%0b,",
                           want.src, want.dst, want.status, want.fin,
                           " got src=%0d dst=%0d status=%0d last=%0b",
                           got.src, got.dst, got.status, got.fin);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_piece(input int c, input logic lastp);
      piece_q.insert(piece_q.size(), '{dmp_pkg::CL_W'(c), lastp});
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (piece_q.size() != 0 || start || move_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_disk_size(input int v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= dmp_pkg::CL_W'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      disk_cfg = dmp_pkg::CL_W'(v);
   endtask

   task automatic queue_random_run(input int n);
      int perm [dmp_pkg::MAX_CLUSTERS];
      int run_len;
      int kind;
      int j;
      int tmp;
      int pos;
      kind = $urandom_range(99);
      for (int k = 0; k < n; k++) perm[k] = k + 1;
      for (int k = n - 1; k > 0; k--) begin
         j = $urandom_range(k);
         tmp = perm[k];
         perm[k] = perm[j];
         perm[j] = tmp;
      end
      if (n == 0) begin
         run_len = $urandom_range(1, 3);
         for (int k = 0; k < run_len; k++) perm[k] = $urandom_range(63);
      end else if (kind < 8 || n == 1) begin
         // full disk
         run_len = n;
      end else begin
         if ($urandom_range(9) == 0) run_len = n - 1;
         else run_len = $urandom_range(1, (n - 1 < 8) ? n - 1 : 8);
         if (kind < 25) begin
            for (int k = 0; k < run_len; k++) perm[k] = k + 1;
         end
         if (kind >= 80 && kind < 90) begin
            pos = $urandom_range(run_len - 1);
            perm[pos] = ($urandom_range(1) == 0) ? 0 : $urandom_range(n + 1, 63);
         end else if (kind >= 90 && run_len >= 2) begin
            pos = $urandom_range(1, run_len - 1);
            perm[pos] = perm[$urandom_range(pos - 1)];
         end
      end
      for (int k = 0; k < run_len; k++) push_piece(perm[k], k == run_len - 1);
   endtask

   initial begin
      int cfg_vals [8];
      int idle_vals [3];
      int prev_size;
      int pushed;
      cfg_vals = '{7, 1, 63, 0, 20, 32, 3, 45};
      idle_vals = '{10, 51, 0};
      for (int k = 1; k <= dmp_pkg::MAX_CLUSTERS; k++) loc[k] = 0;
      for (int k = 0; k <= dmp_pkg::MAX_CLUSTERS; k++) owner[k] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed runs at the reset disk size
      push_piece(1, 1'b1);
      push_piece(32, 1'b1);
      push_piece(2, 1'b0);
      push_piece(1, 1'b1);
      push_piece(3, 1'b0);
      push_piece(5, 1'b1);
      push_piece(0, 1'b0);
      push_piece(3, 1'b1);
      push_piece(5, 1'b0);
      push_piece(33, 1'b1);
      push_piece(63, 1'b1);
      push_piece(4, 1'b0);
      push_piece(4, 1'b1);
      push_piece(7, 1'b0);
      push_piece(2, 1'b0);
      push_piece(9, 1'b0);
      push_piece(1, 1'b1);
      push_piece(31, 1'b0);
      push_piece(30, 1'b1);

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         write_disk_size(cfg_vals[p]);
         @(negedge clock);
         idle_pct = idle_vals[p % 3];
         pushed = 0;
         while (pushed < 48) begin
            prev_size = piece_q.size();
            queue_random_run(eff_size(dmp_pkg::CL_W'(cfg_vals[p])));
            pushed += piece_q.size() - prev_size;
         end
      end

      wait_drained();
      if (fails == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
